// File: sv/rgbc_pkg.sv
// rgbc_pkg: shared types, constants and helpers of the rgb 3x3 convolution block
`timescale 1ns / 1ps
package rgbc_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int DIM_W      = 12;
	localparam int COEF_W     = 48;
	localparam int TAP_W      = 16;
	localparam int PROD_W     = 25;
	localparam int SUM_W      = 29;
	localparam int CFG_IDX_W  = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF2  = 3'd4;

	// item kinds
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	localparam logic [DIM_W-1:0]  RST_WIDTH  = 12'd640;
	localparam logic [DIM_W-1:0]  RST_HEIGHT = 12'd480;
	localparam logic [COEF_W-1:0] RST_COEF1  = 48'd256;

	typedef logic [23:0] pix_t;
	typedef pix_t [2:0] col_t;   // lane v = vertical offset v
	typedef col_t [2:0] grid_t;  // column k = horizontal offset k
	typedef logic signed [PROD_W-1:0] prod_t;

	// clamp a written dimension to 2..hi
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		r = v;
		if (v < DIM_W'(2)) r = DIM_W'(2);
		if (v > hi) r = hi;
		return r;
	endfunction

	// unsigned 8-bit sample times signed q8.8 tap
	function automatic prod_t mul_tap(input logic [7:0] px, input logic signed [TAP_W-1:0] t);
		logic signed [8:0] ps;
		ps = {1'b0, px};
		return ps * t;
	endfunction

	// signed q21.8 sum to 0..255, fraction dropped
	function automatic logic [7:0] clamp_sum(input logic signed [SUM_W-1:0] s);
		logic [7:0] q;
		if (s[SUM_W-1]) q = 8'd0;
		else if (|s[SUM_W-2:16]) q = 8'd255;
		else q = s[15:8];
		return q;
	endfunction

endpackage

// File: sv/rgb_convolution_3x3_mirror.sv
// rgb_convolution_3x3_mirror: streaming rgb 3x3 convolution with mirrored borders
//
//   channel | handshake             | beat contents
//   --------+-----------------------+-----------------------------------------
//   input   | in_valid / in_stall   | func, in_red, in_green, in_blue
//   output  | out_valid / out_stall | out_red, out_green, out_blue, frame_end
//   config  | cfg_write             | cfg_index, cfg_data (no read-back)
//
// One item per clock unless held; results pass stages 1 to 3 and an output register.
// Row-end pixels after the first row give two results; the first holds the pipeline.
// The two previous rows sit in one 2048 x 48 line memory, read and rewritten per pixel.
// The whole pipeline advances together; out_stall holds it and raises in_stall.
// Reset clears control and configuration; the line memory is not cleared.
`timescale 1ns / 1ps
module rgb_convolution_3x3_mirror (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [7:0]                      in_red,
	input  logic [7:0]                      in_green,
	input  logic [7:0]                      in_blue,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      out_red,
	output logic [7:0]                      out_green,
	output logic [7:0]                      out_blue,
	output logic                            frame_end,
	input  logic                            cfg_write,
	input  logic [rgbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgbc_pkg::COEF_W-1:0]     cfg_data
);
	import rgbc_pkg::*;

	// configuration
	logic [DIM_W-1:0]        w_q, h_q;
	logic [2:0][COEF_W-1:0]  coef_q;

	// position counters
	logic [ADDR_W-1:0] col_q;
	logic [DIM_W-1:0]  row_q;

	// pipeline advance
	logic adv, accept;
	logic [1:0] out_cnt_q;

	// stage a decode
	logic              fr_rst, drain_ok, emit1, emit2;
	logic [ADDR_W-1:0] c_a, rd_addr, col_nx;
	logic [DIM_W-1:0]  r_a, row_nx;
	logic [1:0]        cnt_a;

	// stage 1
	logic        valid_s1, drain_s1, col1_s1, tm_s1, cap_s1, d0_s1, dright_s1, fend_s1;
	logic [1:0]  cnt_s1;
	logic [ADDR_W-1:0] c_s1;
	pix_t        pix_s1;

	// line memory, entry = {two rows up, one row up}
	logic [47:0]       line_mem [MAX_WIDTH];
	logic [47:0]       rd_q, rd, wr_data;
	logic              wr_en, fwd_q;
	logic [47:0]       fwd_data_q;

	// column history
	col_t win_a_q, win_b_q;
	col_t dp0_q, dp1_q;

	grid_t grid_a, grid_b;
	col_t  ncol, dcol;

	// stage 2..3
	grid_t       grid_a_s2, grid_b_s2;
	logic [1:0]  cnt_s2, cnt_s3;
	logic        fend_s2, fend_s3;
	prod_t       prod_c [2][3][9];
	prod_t       prod_s3 [2][3][9];
	logic [1:0][23:0] res;

	// output register
	logic [23:0] out0_q, out1_q;
	logic        fend0_q;

	assign adv      = (out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && !out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	// stage a: frame position and read address
	always_comb begin
		fr_rst   = (row_q >= h_q) || ({1'b0, col_q} >= w_q);
		drain_ok = (row_q >= h_q) && ({1'b0, col_q} < w_q);
		r_a      = fr_rst ? '0 : row_q;
		c_a      = fr_rst ? '0 : col_q;
		emit1    = (r_a != '0) && (c_a != '0);
		emit2    = emit1 && ({1'b0, c_a} + DIM_W'(1) == w_q);
		if ({1'b0, c_a} + DIM_W'(1) == w_q) begin
			col_nx = '0;
			row_nx = r_a + DIM_W'(1);
		end else begin
			col_nx = c_a + ADDR_W'(1);
			row_nx = r_a;
		end
		if (func == FUNC_DRAIN) begin
			rd_addr = col_q + ADDR_W'(1);
			cnt_a   = drain_ok ? 2'd1 : 2'd0;
		end else begin
			rd_addr = c_a;
			cnt_a   = emit2 ? 2'd2 : (emit1 ? 2'd1 : 2'd0);
		end
	end

	// configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= RST_WIDTH;
			h_q    <= RST_HEIGHT;
			coef_q <= {COEF_W'(0), RST_COEF1, COEF_W'(0)};
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WIDTH: begin
					w_q   <= clamp_dim(cfg_data[DIM_W-1:0], DIM_W'(MAX_WIDTH));
					col_q <= '0;
					row_q <= '0;
				end
				REG_HEIGHT: begin
					h_q   <= clamp_dim(cfg_data[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
					col_q <= '0;
					row_q <= '0;
				end
				REG_COEF0: coef_q[0] <= cfg_data;
				REG_COEF1: coef_q[1] <= cfg_data;
				REG_COEF2: coef_q[2] <= cfg_data;
				default: ;
			endcase
		end else if (accept) begin
			if (func == FUNC_DRAIN) begin
				if (drain_ok) begin
					if ({1'b0, col_q} + DIM_W'(1) == w_q) begin
						col_q <= '0;
						row_q <= '0;
					end else begin
						col_q <= col_q + ADDR_W'(1);
					end
				end
			end else begin
				col_q <= col_nx;
				row_q <= row_nx;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s1   <= '0;
			fwd_q    <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			cnt_s1   <= accept ? cnt_a : 2'd0;
			fwd_q    <= wr_en && (c_s1 == rd_addr);
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			drain_s1   <= (func == FUNC_DRAIN);
			pix_s1     <= {in_red, in_green, in_blue};
			c_s1       <= rd_addr;
			col1_s1    <= (c_a == ADDR_W'(1));
			tm_s1      <= (r_a == DIM_W'(1));
			cap_s1     <= (r_a + DIM_W'(1) == h_q) && (c_a == '0);
			d0_s1      <= (col_q == '0);
			dright_s1  <= ({1'b0, col_q} + DIM_W'(1) >= w_q);
			fend_s1    <= ({1'b0, col_q} + DIM_W'(1) == w_q);
			fwd_data_q <= wr_data;
		end
	end

	// line memory: read at stage a, rewrite at stage 1
	assign rd      = fwd_q ? fwd_data_q : rd_q;
	assign wr_en   = adv && valid_s1 && !drain_s1;
	assign wr_data = {rd[23:0], pix_s1};

	always_ff @(posedge clk) begin
		if (wr_en) line_mem[c_s1] <= wr_data;
		if (adv) rd_q <= line_mem[rd_addr];
	end

	// build the windows of both results
	always_comb begin
		ncol = {pix_s1, rd[23:0], rd[47:24]};
		// drain column: last row in the middle, row above mirrored below
		dcol = {rd[47:24], rd[23:0], rd[47:24]};
		grid_a = '0;
		grid_b = '0;
		if (drain_s1) begin
			grid_a[0] = d0_s1 ? dcol : dp0_q;
			grid_a[1] = dp1_q;
			grid_a[2] = dright_s1 ? dp0_q : dcol;
		end else begin
			grid_a[0] = col1_s1 ? ncol : win_a_q;
			grid_a[1] = win_b_q;
			grid_a[2] = ncol;
			grid_b[0] = win_b_q;
			grid_b[1] = ncol;
			grid_b[2] = win_b_q;
			for (int k = 0; k < 3; k++) begin
				if (tm_s1) begin
					grid_a[k][0] = grid_a[k][2];
					grid_b[k][0] = grid_b[k][2];
				end
			end
		end
	end

	// column history for pixels and for the drain row
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			if (drain_s1) begin
				if (cnt_s1 != 2'd0) begin
					dp0_q <= dp1_q;
					dp1_q <= dcol;
				end
			end else begin
				win_a_q <= win_b_q;
				win_b_q <= ncol;
				if (cap_s1) dp1_q <= {rd[23:0], pix_s1, rd[23:0]};
			end
		end
	end

	// stage 2 and 3 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
			cnt_s3 <= '0;
		end else if (adv) begin
			cnt_s2 <= valid_s1 ? cnt_s1 : 2'd0;
			cnt_s3 <= cnt_s2;
		end
	end

	// tap products
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int k = 0; k < 3; k++) begin
				for (int v = 0; v < 3; v++) begin
					prod_c[0][ch][3*k+v] = mul_tap(grid_a_s2[k][v][16-8*ch +: 8],
						coef_q[k][16*v +: TAP_W]);
					prod_c[1][ch][3*k+v] = mul_tap(grid_b_s2[k][v][16-8*ch +: 8],
						coef_q[k][16*v +: TAP_W]);
				end
			end
		end
	end

	// stage 2 and 3 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			grid_a_s2 <= grid_a;
			grid_b_s2 <= grid_b;
			fend_s2   <= drain_s1 && fend_s1;
			fend_s3   <= fend_s2;
			prod_s3   <= prod_c;
		end
	end

	// sum of nine products as an adder tree, clamp
	always_comb begin
		logic signed [SUM_W-1:0] acc;
		logic signed [SUM_W-1:0] term [9];
		for (int r = 0; r < 2; r++) begin
			for (int ch = 0; ch < 3; ch++) begin
				for (int t = 0; t < 9; t++) term[t] = SUM_W'(prod_s3[r][ch][t]);
				acc = ((term[0] + term[1]) + (term[2] + term[3]))
					+ ((term[4] + term[5]) + (term[6] + term[7])) + term[8];
				res[r][16-8*ch +: 8] = clamp_sum(acc);
			end
		end
	end

	// output register, second result of a row end follows the first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (adv) begin
			out_cnt_q <= cnt_s3;
		end else if (!out_stall) begin
			out_cnt_q <= 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out0_q  <= res[0];
			out1_q  <= res[1];
			fend0_q <= fend_s3;
		end else if (!out_stall) begin
			out0_q  <= out1_q;
			fend0_q <= 1'b0;
		end
	end

	assign out_valid = (out_cnt_q != 2'd0);
	assign out_red   = out0_q[23:16];
	assign out_green = out0_q[15:8];
	assign out_blue  = out0_q[7:0];
	assign frame_end = fend0_q;

endmodule
